@@ hw/rtl/hifs_pkg.sv @@
// Shared types, constants and codes for the hash index frame stack.
// Used by hifs_datapath, hifs_ctrl and hash_index_frame_stack; no dependencies.
`timescale 1ns / 1ps

package hifs_pkg;

    localparam int ENTRIES_DEF = 1024;
    localparam int BUCKETS_DEF = 256;
    localparam int FRAMES_DEF  = 16;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_PUSH   = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key_hash;
        logic [3:0]  frame_sel;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] result_index;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture request
        logic clr_step;    // one bucket clear step (reset sweep)
        logic ins_wr;      // write entry and head
        logic head_rd;     // read bucket head of request key
        logic ent_rd;      // read entry at current pointer
        logic push_wr;     // record frame base
        logic pop_rd;      // read key and link of top live entry
        logic pop_wr;      // restore head, decrement count
        logic pop_done;    // drop frame
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic table_full;
        logic stack_full;
        logic pop_ok;
        logic ptr_end;
        logic key_hit;
        logic pop_more;
    } sts_t;

endpackage

@@ hw/rtl/hifs_datapath.sv @@
// Datapath of the hash index frame stack: bucket heads, entry table, frame stack.
// Depends on hifs_pkg; driven by hifs_ctrl.
`timescale 1ns / 1ps

module hifs_datapath
    import hifs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int FRAMES  = FRAMES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic [9:0] ent_index,
    output logic [9:0] frame_index
);

    localparam int PW = $clog2(ENTRIES + 1);
    localparam int EW = $clog2(ENTRIES);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int FW = $clog2(FRAMES);
    localparam int DW = $clog2(FRAMES + 1);
    localparam logic [PW-1:0] END_PTR = PW'(ENTRIES);

    // Memories.
    logic [PW-1:0] heads_mem [BUCKETS];
    logic [31:0]   keys_mem  [ENTRIES];
    logic [PW-1:0] links_mem [ENTRIES];
    logic [PW-1:0] bases_mem [FRAMES];

    logic [1:0]    op_reg;
    logic [31:0]   key_reg;
    logic [3:0]    sel_reg;
    logic [PW-1:0] count_reg;
    logic [DW-1:0] depth_reg;
    logic [BW-1:0] clr_reg;
    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] base_reg;
    logic [31:0]   rkey_reg;
    logic [PW-1:0] rlink_reg;
    logic [PW-1:0] head_q;

    logic [BW-1:0] key_bkt;
    logic [BW-1:0] pop_bkt;
    logic [PW-1:0] base_clip;
    logic [EW-1:0] top_idx;

    assign key_bkt   = BW'(key_reg % 32'(BUCKETS));
    assign pop_bkt   = BW'(rkey_reg % 32'(BUCKETS));
    assign base_clip = (base_reg > count_reg) ? count_reg : base_reg;
    assign top_idx   = EW'(count_reg - PW'(1));

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            depth_reg <= DW'(1);
            clr_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_reg <= clr_reg + BW'(1);
            if (cmd.ins_wr)
                count_reg <= count_reg + PW'(1);
            if (cmd.push_wr)
                depth_reg <= depth_reg + DW'(1);
            if (cmd.pop_wr)
                count_reg <= count_reg - PW'(1);
            if (cmd.pop_done)
            begin
                count_reg <= base_clip;
                depth_reg <= depth_reg - DW'(1);
            end
        end
    end

    // Request capture and frame base read.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key_hash;
            sel_reg <= req.frame_sel;
        end
        if (cmd.load)
            base_reg <= bases_mem[FW'(req.frame_sel)];
    end

    // Bucket head memory.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            heads_mem[clr_reg] <= END_PTR;
        else if (cmd.ins_wr)
            heads_mem[key_bkt] <= count_reg;
        else if (cmd.pop_wr)
            heads_mem[pop_bkt] <= rlink_reg;
        head_q <= heads_mem[key_bkt];
    end

    // Entry memories.
    always_ff @(posedge clk)
    begin
        if (cmd.ins_wr)
        begin
            keys_mem[EW'(count_reg)]  <= key_reg;
            links_mem[EW'(count_reg)] <= head_q;
        end
        if (cmd.ent_rd)
        begin
            rkey_reg  <= keys_mem[EW'(ptr_reg)];
            rlink_reg <= links_mem[EW'(ptr_reg)];
        end
        else if (cmd.pop_rd)
        begin
            rkey_reg  <= keys_mem[top_idx];
            rlink_reg <= links_mem[top_idx];
        end
    end

    // Chain pointer: starts at the head, then follows links.
    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
            ptr_reg <= head_q;
        else if (cmd.ent_rd)
            ptr_reg <= links_mem[EW'(ptr_reg)];
    end

    // Frame base memory.
    always_ff @(posedge clk)
    begin
        if (cmd.push_wr)
            bases_mem[FW'(depth_reg)] <= count_reg;
        else if (cmd.pop_done)
            bases_mem[FW'(sel_reg)] <= '0;
        if (!rst_n)
            bases_mem[0] <= '0;
    end

    logic [PW-1:0] hit_ptr_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.ent_rd)
            hit_ptr_reg <= ptr_reg;
    end

    // Status toward the controller.
    always_comb
    begin
        sts.clr_last   = (clr_reg == BW'(BUCKETS - 1));
        sts.table_full = (count_reg >= END_PTR);
        sts.stack_full = (depth_reg >= DW'(FRAMES));
        sts.pop_ok     = (sel_reg != 4'd0) && (DW'(sel_reg) == depth_reg - DW'(1))
                         && (32'(sel_reg) < 32'(FRAMES));
        sts.ptr_end    = (ptr_reg >= END_PTR);
        sts.key_hit    = (rkey_reg == key_reg);
        sts.pop_more   = (count_reg > base_clip);
    end

    assign ent_index   = (op_reg == OP_INSERT) ? 10'(count_reg) : 10'(hit_ptr_reg);
    assign frame_index = 10'(depth_reg);

endmodule

@@ hw/rtl/hifs_ctrl.sv @@
// Controller state machine for the hash index frame stack.
// Depends on hifs_pkg; commands hifs_datapath.
`timescale 1ns / 1ps

module hifs_ctrl
    import hifs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] opcode,
    input  sts_t       sts,
    input  logic [9:0] ent_index,
    input  logic [9:0] frame_index,
    output cmd_t       cmd,
    output logic       busy,
    output logic       done,
    output rsp_t       result
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HEAD  = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_FPTR  = 4'd4;
    localparam logic [3:0] S_FRD   = 4'd5;
    localparam logic [3:0] S_FCMP  = 4'd6;
    localparam logic [3:0] S_PUSH  = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_PRD   = 4'd9;
    localparam logic [3:0] S_PWR   = 4'd10;
    localparam logic [3:0] S_DISP  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       done_reg, done_next;
    rsp_t       result_reg, result_next;
    logic [1:0] op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.load)
            op_reg <= opcode;
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cmd         = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (op_reg)
                    OP_INSERT: state_next = S_HEAD;
                    OP_FIND:   state_next = S_HEAD;
                    OP_PUSH:   state_next = S_PUSH;
                    default:   state_next = S_PCHK;
                endcase
            end
            S_HEAD:
            begin
                // Head read data is valid after this cycle.
                state_next = (op_reg == OP_INSERT) ? S_INS : S_FPTR;
            end
            S_INS:
            begin
                done_next = 1'b1;
                if (sts.table_full)
                    result_next = '{status: ST_FULL, result_index: '0};
                else
                begin
                    cmd.ins_wr  = 1'b1;
                    result_next = '{status: ST_OK, result_index: ent_index};
                end
                state_next = S_IDLE;
            end
            S_FPTR:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_FRD;
            end
            S_FRD:
            begin
                if (sts.ptr_end)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_MISS, result_index: '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_FCMP;
                end
            end
            S_FCMP:
            begin
                if (sts.key_hit)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_OK, result_index: ent_index};
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_FRD;
            end
            S_PUSH:
            begin
                done_next = 1'b1;
                if (sts.stack_full)
                    result_next = '{status: ST_FULL, result_index: '0};
                else
                begin
                    cmd.push_wr = 1'b1;
                    result_next = '{status: ST_OK, result_index: frame_index};
                end
                state_next = S_IDLE;
            end
            S_PCHK:
            begin
                if (!sts.pop_ok)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_REFUSED, result_index: '0};
                    state_next  = S_IDLE;
                end
                else if (sts.pop_more)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_PWR;
                end
                else
                begin
                    cmd.pop_done = 1'b1;
                    done_next    = 1'b1;
                    result_next  = '{status: ST_OK, result_index: '0};
                    state_next   = S_IDLE;
                end
            end
            S_PWR:
            begin
                cmd.pop_wr = 1'b1;
                state_next = S_PCHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("load outside idle");
    a_done_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result without return to idle");
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.ins_wr, cmd.pop_wr, cmd.clr_step}) <= 1)
        else $error("head memory double write");
    a_pop_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_rd |=> cmd.pop_wr)
        else $error("pop read not followed by write");
`endif

endmodule

@@ hw/rtl/hash_index_frame_stack.sv @@
// Top level of the hash index frame stack: controller plus datapath.
// Depends on hifs_pkg, hifs_ctrl and hifs_datapath.
//
// Channel  Signals                     Handshake
// -------  --------------------------  -------------------------------
// request  start, busy, req            taken when start && !busy
// result   done, result                one cycle strobe, no back-pressure
//
// An insert goes from dispatch through the head read to the entry write, and a
// push from dispatch to the frame write. A find reads the bucket head, then reads
// and compares one chain entry at a time until a key hit or the chain end (miss).
// A pop checks the frame, then unlinks each entry with an entry read and then a
// head write; a refused pop ends at the check. Busy drops in the strobe cycle. After
// reset a clearing pass sets every bucket head to end-of-chain; busy is high then.
`timescale 1ns / 1ps

module hash_index_frame_stack
    import hifs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int FRAMES  = FRAMES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t result
);

    cmd_t       cmd;
    sts_t       sts;
    logic [9:0] ent_index;
    logic [9:0] frame_index;

    hifs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (req.opcode),
        .sts         (sts),
        .ent_index   (ent_index),
        .frame_index (frame_index),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    hifs_datapath #(
        .ENTRIES (ENTRIES),
        .BUCKETS (BUCKETS),
        .FRAMES  (FRAMES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cmd         (cmd),
        .sts         (sts),
        .ent_index   (ent_index),
        .frame_index (frame_index)
    );

endmodule
